// ===== hw/rtl/sgd_pkg.sv =====
// Shared types, codes and constants for the swipe gesture detector.
// Used by swipe_gesture_detector; it depends on nothing else.
package sgd_pkg;

  // Default values of the top level parameters.
  localparam int RING_DEPTH_DEF   = 32;
  localparam int WINDOW_GAP_DEF   = 5;
  localparam int WINDOW_COUNT_DEF = 15;

  // Fixed arithmetic widths, set by the field widths and the parameter ranges.
  localparam int MUL_A_W   = 36;
  localparam int MUL_B_W   = 20;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int DT_SUM_W  = 36;
  localparam int PIX_SUM_W = 20;
  localparam int DIV_W     = 40;
  localparam int SPEED_W   = 24;
  localparam int CFG_W     = 20;

  localparam logic [MUL_B_W-1:0] USEC_PER_S = 20'd1000000;
  localparam logic [31:0]        ZERO_DT_US = 32'd10;
  localparam logic [7:0]         COUNT_MAX  = 8'd255;

  // Event commands.
  typedef enum logic [1:0] {
    CMD_PRESS   = 2'd0,
    CMD_MOVE    = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Directions; STILL is internal to the window classification.
  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_UP    = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_LEFT  = 3'd3,
    DIR_RIGHT = 3'd4,
    DIR_STILL = 3'd5
  } dir_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_DIR_MASK = 2'd0,
    CFG_SETTLE   = 2'd1,
    CFG_STALL    = 2'd2,
    CFG_MIN_SPD  = 2'd3
  } cfg_idx_t;

  // One input request.
  typedef struct packed {
    logic [1:0]         command;
    logic [2:0]         button;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [31:0]        time_us;
    logic               suppress;
  } in_t;

  // One result.
  typedef struct packed {
    logic               accepted;
    logic [2:0]         direction;
    logic [SPEED_W-1:0] swipe_speed;
    logic               fired;
  } out_t;

  // One ring entry.
  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic [31:0]        t;
    logic [7:0]         count;
  } entry_t;

endpackage

// ===== hw/rtl/sgd_ram.sv =====
// Generic simple dual port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module sgd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/swipe_gesture_detector.sv =====
// Swipe gesture detector top level: point ring, settle walk, window classifier, divider.
// Depends on sgd_pkg and sgd_ram.
//
// Press and move requests give no result. A release that does not match the active button,
// or that comes while no press is tracked, gives its result in the next cycle. A matching
// release walks the ring back over the settled points, up to RING_DEPTH points. It then
// checks the point count and classifies each window with one ring read for each end point.
// A moving window also makes two passes through the shared multiplier. Up to WINDOW_COUNT+1
// windows are classified. Last comes a restoring divider: setup in ST_DV_M1 to ST_DV_M3,
// then one quotient bit per cycle. busy is high while a release is evaluated. Each result
// is on out_res for one cycle with out_valid high and must be taken then; the receiver
// cannot stall the block.
module swipe_gesture_detector #(
  parameter int RING_DEPTH   = sgd_pkg::RING_DEPTH_DEF,
  parameter int WINDOW_GAP   = sgd_pkg::WINDOW_GAP_DEF,
  parameter int WINDOW_COUNT = sgd_pkg::WINDOW_COUNT_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  sgd_pkg::in_t             in_req,
  output logic                     out_valid,
  output sgd_pkg::out_t            out_res,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [sgd_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int SLOT_W  = $clog2(RING_DEPTH);
  localparam int WIN_W   = $clog2(WINDOW_COUNT + 1);
  localparam int ENTRY_W = $bits(sgd_pkg::entry_t);
  localparam int CNT_W   = $clog2(sgd_pkg::DIV_W + 1);

  typedef enum logic [4:0] {
    ST_IDLE, ST_SET_A, ST_SET_D, ST_CNT_A, ST_CNT_D, ST_WC_A, ST_WC_D, ST_WP_A, ST_WP_D,
    ST_W_M1, ST_W_M2, ST_W_CMP, ST_W_POST, ST_DV_M1, ST_DV_M2, ST_DV_M3, ST_DV_RUN, ST_DONE
  } state_t;

  // Ring index helpers that wrap at any depth.
  function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] s,
                                                  input logic [SLOT_W-1:0] k);
    logic [SLOT_W:0] wide;
    wide = (s >= k) ? ({1'b0, s} - {1'b0, k})
                    : ({1'b0, s} + (SLOT_W+1)'(RING_DEPTH) - {1'b0, k});
    return wide[SLOT_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
    return (s == SLOT_W'(RING_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  localparam logic [SLOT_W-1:0] ONE_BACK  = SLOT_W'(1);
  localparam logic [SLOT_W-1:0] WIN_BACK  = SLOT_W'(WINDOW_GAP + 1);
  localparam logic [7:0]        MIN_COUNT = 8'(WINDOW_GAP + WINDOW_COUNT);

  state_t state_r;

  // Configuration registers.
  logic [3:0]  mask_r;
  logic [19:0] settle_r;
  logic [19:0] stall_r;
  logic [15:0] min_spd_r;

  // Tracking state.
  logic                tracking_r;
  logic [2:0]          active_r;
  logic [SLOT_W-1:0]   newest_r;
  logic [7:0]          newest_cnt_r;
  logic [RING_DEPTH-1:0] valid_r;

  // Evaluation registers.
  logic [SLOT_W-1:0]   addr_r;
  logic                rd_ok_r;
  logic [SLOT_W-1:0]   cand_r;
  logic [SLOT_W-1:0]   iter_r;
  logic [SLOT_W-1:0]   cur_r;
  logic [31:0]         end_r;
  logic                sup_r;
  logic                retried_r;
  logic [WIN_W-1:0]    win_r;
  logic signed [15:0]  xc_r;
  logic signed [15:0]  yc_r;
  logic [31:0]         tc_r;
  logic [31:0]         dt_w_r;
  logic [15:0]         pix_w_r;
  sgd_pkg::dir_t       cand_dir_r;
  sgd_pkg::dir_t       wdir_r;
  sgd_pkg::dir_t       dir_r;
  logic [sgd_pkg::DT_SUM_W-1:0]  dt_sum_r;
  logic [sgd_pkg::PIX_SUM_W-1:0] pix_sum_r;
  logic [sgd_pkg::MUL_P_W-1:0]   prod_r;
  logic [47:0]                   lhs_r;
  logic [sgd_pkg::DIV_W-1:0]     num_r;
  logic [sgd_pkg::DIV_W-1:0]     den_r;
  logic [sgd_pkg::DIV_W-1:0]     rem_r;
  logic [CNT_W-1:0]              bit_r;
  logic                          out_valid_r;
  sgd_pkg::out_t                 out_r;

  // Ring write port, driven straight from an accepted request.
  logic              accept;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  sgd_pkg::entry_t   ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  sgd_pkg::entry_t   rd_e;
  logic              is_press;
  logic              is_move;
  logic              is_rel_ok;
  logic              rel_reject;
  logic [7:0]        next_cnt;

  assign accept    = start && (state_r == ST_IDLE);
  assign is_press  = accept && (in_req.command == sgd_pkg::CMD_PRESS) && (active_r == 3'd0);
  assign is_move   = accept && (in_req.command == sgd_pkg::CMD_MOVE) && tracking_r;
  assign is_rel_ok = accept && (in_req.command == sgd_pkg::CMD_RELEASE) && tracking_r &&
                     (in_req.button == active_r);
  assign rel_reject = accept && (in_req.command == sgd_pkg::CMD_RELEASE) && !is_rel_ok;
  assign next_cnt  = (newest_cnt_r == sgd_pkg::COUNT_MAX) ? newest_cnt_r : newest_cnt_r + 8'd1;
  assign ram_we    = is_press || is_move || is_rel_ok;
  assign ram_waddr = is_press ? '0 : slot_next(newest_r);

  always_comb begin
    ram_wdata.x     = in_req.pos_x;
    ram_wdata.y     = in_req.pos_y;
    ram_wdata.t     = in_req.time_us;
    ram_wdata.count = is_press ? 8'd1 : next_cnt;
  end

  sgd_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(addr_r),
    .rdata(ram_rdata)
  );

  // Entries cleared by a press read as zero.
  assign rd_e = rd_ok_r ? sgd_pkg::entry_t'(ram_rdata) : '0;

  // Shared multiplier with operands chosen by the sequencer.
  logic [sgd_pkg::MUL_A_W-1:0] mul_a;
  logic [sgd_pkg::MUL_B_W-1:0] mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_W_M1: begin
        mul_a = sgd_pkg::MUL_A_W'(pix_w_r);
        mul_b = sgd_pkg::USEC_PER_S;
      end
      ST_W_M2: begin
        mul_a = sgd_pkg::MUL_A_W'(dt_w_r);
        mul_b = sgd_pkg::MUL_B_W'(min_spd_r);
      end
      ST_DV_M1: begin
        mul_a = sgd_pkg::MUL_A_W'(pix_sum_r);
        mul_b = sgd_pkg::USEC_PER_S;
      end
      ST_DV_M2: begin
        mul_a = dt_sum_r;
        mul_b = sgd_pkg::MUL_B_W'(WINDOW_COUNT);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Window pieces from the current point and the point one window back.
  logic [32:0]        w_dt;
  logic signed [16:0] w_dx;
  logic signed [16:0] w_dy;
  logic [16:0]        w_ax;
  logic [16:0]        w_ay;
  logic               w_still;
  logic [32:0]        set_diff;
  logic               set_stop;

  always_comb begin
    w_dt     = {1'b0, tc_r} - {1'b0, rd_e.t};
    w_dx     = 17'(xc_r) - 17'(rd_e.x);
    w_dy     = 17'(yc_r) - 17'(rd_e.y);
    w_ax     = w_dx[16] ? 17'(-w_dx) : 17'(w_dx);
    w_ay     = w_dy[16] ? 17'(-w_dy) : 17'(w_dy);
    w_still  = (w_dx == 17'sd0) && (w_dy == 17'sd0);
    set_diff = {1'b0, end_r} - {1'b0, rd_e.t};
    set_stop = (!set_diff[32] && (set_diff[31:0] > {12'd0, settle_r})) ||
               (rd_e.count == 8'd0);
  end

  // One restoring divider step.
  logic [sgd_pkg::DIV_W:0] div_sh;
  logic                    div_ge;

  always_comb begin
    div_sh = {rem_r, num_r[sgd_pkg::DIV_W-1]};
    div_ge = div_sh >= {1'b0, den_r};
  end

  logic dir_allowed;
  always_comb begin
    dir_allowed = 1'b0;
    case (wdir_r)
      sgd_pkg::DIR_UP:    dir_allowed = mask_r[0];
      sgd_pkg::DIR_DOWN:  dir_allowed = mask_r[1];
      sgd_pkg::DIR_LEFT:  dir_allowed = mask_r[2];
      sgd_pkg::DIR_RIGHT: dir_allowed = mask_r[3];
      default:            dir_allowed = 1'b0;
    endcase
  end

  // Sequencer, configuration and registered result.
  always_ff @(posedge clk) begin
    prod_r  <= mul_a * mul_b;
    rd_ok_r <= valid_r[addr_r];

    if (!rst_n) begin
      state_r      <= ST_IDLE;
      mask_r       <= 4'd15;
      settle_r     <= 20'd10000;
      stall_r      <= 20'd10000;
      min_spd_r    <= 16'd0;
      tracking_r   <= 1'b0;
      active_r     <= 3'd0;
      newest_r     <= '0;
      newest_cnt_r <= 8'd0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      // A result leaves on a rejected release or at the end of a matching one.
      out_valid_r <= rel_reject || (state_r == ST_DONE);

      // Configuration writes.
      if (cfg_we) begin
        unique case (sgd_pkg::cfg_idx_t'(cfg_index))
          sgd_pkg::CFG_DIR_MASK: mask_r    <= cfg_wdata[3:0];
          sgd_pkg::CFG_SETTLE:   settle_r  <= cfg_wdata;
          sgd_pkg::CFG_STALL:    stall_r   <= cfg_wdata;
          sgd_pkg::CFG_MIN_SPD:  min_spd_r <= cfg_wdata[15:0];
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (is_press) begin
            valid_r      <= RING_DEPTH'(1);
            newest_r     <= '0;
            newest_cnt_r <= 8'd1;
            tracking_r   <= 1'b1;
            active_r     <= in_req.button;
          end else if (is_move) begin
            valid_r[ram_waddr] <= 1'b1;
            newest_r           <= ram_waddr;
            newest_cnt_r       <= next_cnt;
          end else if (is_rel_ok) begin
            valid_r[ram_waddr] <= 1'b1;
            newest_r           <= ram_waddr;
            newest_cnt_r       <= next_cnt;
            end_r              <= in_req.time_us;
            sup_r              <= in_req.suppress;
            cur_r              <= ram_waddr;
            cand_r             <= slot_back(ram_waddr, ONE_BACK);
            addr_r             <= slot_back(ram_waddr, ONE_BACK);
            iter_r             <= '0;
            state_r            <= ST_SET_A;
          end else if (rel_reject) begin
            // Release without a matching press.
            out_r <= '0;
          end
        end

        // Walk back over points that fall within the settle time.
        ST_SET_A: state_r <= ST_SET_D;
        ST_SET_D: begin
          if (set_stop) begin
            cur_r   <= slot_next(cand_r);
            addr_r  <= slot_next(cand_r);
            state_r <= ST_CNT_A;
          end else if (iter_r == SLOT_W'(RING_DEPTH - 1)) begin
            addr_r  <= cur_r;
            state_r <= ST_CNT_A;
          end else begin
            iter_r  <= iter_r + 1'b1;
            cand_r  <= slot_back(cand_r, ONE_BACK);
            addr_r  <= slot_back(cand_r, ONE_BACK);
            state_r <= ST_SET_A;
          end
        end

        // The settled newest point must have enough points behind it.
        ST_CNT_A: state_r <= ST_CNT_D;
        ST_CNT_D: begin
          if (rd_e.count <= MIN_COUNT) begin
            dir_r   <= sgd_pkg::DIR_NONE;
            num_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            retried_r <= 1'b0;
            win_r     <= '0;
            addr_r    <= cur_r;
            state_r   <= ST_WC_A;
          end
        end

        // Read both ends of a window.
        ST_WC_A: state_r <= ST_WC_D;
        ST_WC_D: begin
          xc_r    <= rd_e.x;
          yc_r    <= rd_e.y;
          tc_r    <= rd_e.t;
          addr_r  <= slot_back(cur_r, WIN_BACK);
          state_r <= ST_WP_A;
        end
        ST_WP_A: state_r <= ST_WP_D;

        // Early window checks; a moving window goes on to the speed test.
        ST_WP_D: begin
          if (w_dt[32] || (rd_e.count == 8'd1) ||
              (w_still && (w_dt[31:0] > {12'd0, stall_r}))) begin
            wdir_r  <= sgd_pkg::DIR_NONE;
            state_r <= ST_W_POST;
          end else if (w_still) begin
            wdir_r  <= sgd_pkg::DIR_STILL;
            state_r <= ST_W_POST;
          end else begin
            dt_w_r <= (w_dt[31:0] == 32'd0) ? sgd_pkg::ZERO_DT_US : w_dt[31:0];
            if (w_ay > w_ax) begin
              pix_w_r    <= w_ay[15:0];
              cand_dir_r <= (w_dy > 17'sd0) ? sgd_pkg::DIR_DOWN : sgd_pkg::DIR_UP;
            end else begin
              pix_w_r    <= w_ax[15:0];
              cand_dir_r <= (w_dx > 17'sd0) ? sgd_pkg::DIR_RIGHT : sgd_pkg::DIR_LEFT;
            end
            state_r <= ST_W_M1;
          end
        end
        ST_W_M1: state_r <= ST_W_M2;
        ST_W_M2: begin
          lhs_r   <= prod_r[47:0];
          state_r <= ST_W_CMP;
        end
        ST_W_CMP: begin
          wdir_r  <= (lhs_r > prod_r[47:0]) ? cand_dir_r : sgd_pkg::DIR_NONE;
          state_r <= ST_W_POST;
        end

        // Combine the window verdict with the ones before it.
        ST_W_POST: begin
          if (win_r == '0) begin
            if ((wdir_r == sgd_pkg::DIR_STILL) && !retried_r) begin
              retried_r <= 1'b1;
              cur_r     <= slot_back(cur_r, ONE_BACK);
              addr_r    <= slot_back(cur_r, ONE_BACK);
              state_r   <= ST_WC_A;
            end else if (!dir_allowed) begin
              dir_r   <= sgd_pkg::DIR_NONE;
              num_r   <= '0;
              state_r <= ST_DONE;
            end else begin
              dir_r     <= wdir_r;
              dt_sum_r  <= sgd_pkg::DT_SUM_W'(dt_w_r);
              pix_sum_r <= sgd_pkg::PIX_SUM_W'(pix_w_r);
              win_r     <= WIN_W'(1);
              if (WINDOW_COUNT == 1) begin
                state_r <= ST_DV_M1;
              end else begin
                cur_r   <= slot_back(cur_r, ONE_BACK);
                addr_r  <= slot_back(cur_r, ONE_BACK);
                state_r <= ST_WC_A;
              end
            end
          end else if (wdir_r != dir_r) begin
            dir_r   <= sgd_pkg::DIR_NONE;
            num_r   <= '0;
            state_r <= ST_DONE;
          end else begin
            dt_sum_r  <= dt_sum_r + sgd_pkg::DT_SUM_W'(dt_w_r);
            pix_sum_r <= pix_sum_r + sgd_pkg::PIX_SUM_W'(pix_w_r);
            if (win_r == WIN_W'(WINDOW_COUNT - 1)) begin
              state_r <= ST_DV_M1;
            end else begin
              win_r   <= win_r + 1'b1;
              cur_r   <= slot_back(cur_r, ONE_BACK);
              addr_r  <= slot_back(cur_r, ONE_BACK);
              state_r <= ST_WC_A;
            end
          end
        end

        // Speed: summed pixels times one million over summed time times window count.
        ST_DV_M1: state_r <= ST_DV_M2;
        ST_DV_M2: begin
          num_r   <= prod_r[sgd_pkg::DIV_W-1:0];
          state_r <= ST_DV_M3;
        end
        ST_DV_M3: begin
          den_r   <= prod_r[sgd_pkg::DIV_W-1:0];
          rem_r   <= '0;
          bit_r   <= '0;
          state_r <= ST_DV_RUN;
        end
        ST_DV_RUN: begin
          if (div_ge) begin
            rem_r <= sgd_pkg::DIV_W'(div_sh - {1'b0, den_r});
          end else begin
            rem_r <= div_sh[sgd_pkg::DIV_W-1:0];
          end
          num_r <= {num_r[sgd_pkg::DIV_W-2:0], div_ge};
          bit_r <= bit_r + 1'b1;
          if (bit_r == CNT_W'(sgd_pkg::DIV_W - 1)) begin
            state_r <= ST_DONE;
          end
        end

        // Deliver the release result and end tracking.
        ST_DONE: begin
          out_r.accepted       <= 1'b1;
          out_r.direction      <= dir_r;
          out_r.swipe_speed    <= (|num_r[sgd_pkg::DIV_W-1:sgd_pkg::SPEED_W]) ?
                                  {sgd_pkg::SPEED_W{1'b1}} : num_r[sgd_pkg::SPEED_W-1:0];
          out_r.fired          <= (dir_r != sgd_pkg::DIR_NONE) && !sup_r;
          tracking_r           <= 1'b0;
          active_r             <= 3'd0;
          state_r              <= ST_IDLE;
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

// ===== verif/tb_swipe_gesture_detector.sv =====
// Self-checking testbench for swipe_gesture_detector: directed swipes, then random gestures.
// Depends on sgd_pkg and the swipe_gesture_detector RTL; every release is checked against a
// predictor of the point ring and window classifier kept inside this file.
module tb_swipe_gesture_detector;

  localparam int DEPTH = sgd_pkg::RING_DEPTH_DEF;
  localparam int GAP   = sgd_pkg::WINDOW_GAP_DEF;
  localparam int WINS  = sgd_pkg::WINDOW_COUNT_DEF;

  // Results that can be read off at a glance.
  localparam sgd_pkg::out_t REJECTED    = '0;
  localparam sgd_pkg::out_t SHORT_SWIPE = {1'b1, sgd_pkg::DIR_NONE, 24'd0, 1'b0};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  sgd_pkg::in_t in_req = '0;
  logic out_valid;
  sgd_pkg::out_t out_res;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [sgd_pkg::CFG_W-1:0] cfg_wdata = '0;

  swipe_gesture_detector i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_res(out_res), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Predictor state: configuration and the point ring.
  logic [3:0]  mask_q;
  logic [19:0] settle_q, stall_q;
  logic [15:0] min_spd_q;
  logic signed [15:0] rx [DEPTH];
  logic signed [15:0] ry [DEPTH];
  logic [31:0] rt [DEPTH];
  logic [7:0]  rc [DEPTH];
  int unsigned newest;
  bit tracking_q;
  logic [2:0] act_btn;

  sgd_pkg::out_t swipe_results[$];
  int mismatches = 0;

  function automatic int unsigned wrap_back(int unsigned s, int unsigned k);
    return (s + DEPTH - (k % DEPTH)) % DEPTH;
  endfunction

  // Classifies one window ending at slot c; returns a direction code.
  function automatic sgd_pkg::dir_t window_dir(int unsigned c, output longint dt_o,
                                               output longint pix_o);
    int unsigned p;
    longint dt, dx, dy, ax, ay, major;
    bit still;
    p = wrap_back(c, GAP + 1);
    dt = longint'(rt[c]) - longint'(rt[p]);
    dx = longint'(rx[c]) - longint'(rx[p]);
    dy = longint'(ry[c]) - longint'(ry[p]);
    ax = dx < 0 ? -dx : dx;
    ay = dy < 0 ? -dy : dy;
    still = (ax == 0 && ay == 0);
    dt_o = 0;
    pix_o = 0;
    if (dt < 0 || (dt > longint'(stall_q) && still) || rc[p] == 8'd1) return sgd_pkg::DIR_NONE;
    if (dt == 0) dt = 10;
    if (still) return sgd_pkg::DIR_STILL;
    major = (ay > ax) ? ay : ax;
    if (major * 1000000 <= longint'(min_spd_q) * dt) return sgd_pkg::DIR_NONE;
    dt_o = dt;
    pix_o = major;
    if (ay > ax) return dy > 0 ? sgd_pkg::DIR_DOWN : sgd_pkg::DIR_UP;
    return dx > 0 ? sgd_pkg::DIR_RIGHT : sgd_pkg::DIR_LEFT;
  endfunction

  function automatic void store_point(logic signed [15:0] x, logic signed [15:0] y,
                                      logic [31:0] t);
    int unsigned cur;
    cur = (newest + 1) % DEPTH;
    rc[cur] = (rc[newest] == 8'd255) ? 8'd255 : rc[newest] + 8'd1;
    rx[cur] = x;
    ry[cur] = y;
    rt[cur] = t;
    newest = cur;
  endfunction

  // Settles the tail of the swipe and grades its windows until one fails.
  function automatic sgd_pkg::dir_t grade_swipe(output logic [23:0] speed);
    int unsigned cur, cand;
    longint dt, pix, dt_sum, pix_sum, q;
    sgd_pkg::dir_t d;
    speed = '0;
    cur = newest;
    cand = cur;
    for (int i = 0; i < DEPTH; i++) begin
      cand = wrap_back(cand, 1);
      if (longint'(rt[newest]) - longint'(rt[cand]) > longint'(settle_q) || rc[cand] == 0) begin
        cur = (cand + 1) % DEPTH;
        break;
      end
    end
    if (rc[cur] <= GAP + WINS) return sgd_pkg::DIR_NONE;
    d = window_dir(cur, dt, pix);
    if (d == sgd_pkg::DIR_STILL) begin
      cur = wrap_back(cur, 1);
      d = window_dir(cur, dt, pix);
    end
    if (d == sgd_pkg::DIR_NONE || d == sgd_pkg::DIR_STILL || mask_q[d - 1] == 1'b0)
      return sgd_pkg::DIR_NONE;
    dt_sum = dt;
    pix_sum = pix;
    for (int i = 1; i < WINS; i++) begin
      cur = wrap_back(cur, 1);
      if (window_dir(cur, dt, pix) != d) return sgd_pkg::DIR_NONE;
      dt_sum += dt;
      pix_sum += pix;
    end
    q = (pix_sum * 1000000) / (dt_sum * WINS);
    speed = q > 64'hFFFFFF ? 24'hFFFFFF : q[23:0];
    return d;
  endfunction

  function automatic void clear_ring();
    for (int i = 0; i < DEPTH; i++) begin
      rx[i] = '0; ry[i] = '0; rt[i] = '0; rc[i] = '0;
    end
    newest = 0;
  endfunction

  // Applies one request to the predictor and queues any expected result.
  function automatic void predict_request(sgd_pkg::in_t r);
    sgd_pkg::out_t o;
    sgd_pkg::dir_t d;
    logic [23:0] spd;
    o = '0;
    case (r.command)
      sgd_pkg::CMD_PRESS: begin
        if (act_btn == 3'd0) begin
          clear_ring();
          rx[0] = r.pos_x; ry[0] = r.pos_y; rt[0] = r.time_us; rc[0] = 8'd1;
          tracking_q = 1'b1;
          act_btn = r.button;
        end
      end
      sgd_pkg::CMD_MOVE: begin
        if (tracking_q) store_point(r.pos_x, r.pos_y, r.time_us);
      end
      sgd_pkg::CMD_RELEASE: begin
        if (tracking_q && r.button == act_btn) begin
          store_point(r.pos_x, r.pos_y, r.time_us);
          d = grade_swipe(spd);
          tracking_q = 1'b0;
          act_btn = 3'd0;
          o.accepted = 1'b1;
          o.direction = d;
          o.swipe_speed = spd;
          o.fired = (d != sgd_pkg::DIR_NONE) && !r.suppress;
        end
        swipe_results.push_back(o);
      end
      default: ;
    endcase
  endfunction

  // Result checker: the receiver cannot stall, so every strobe is taken.
  always @(posedge clk) begin
    sgd_pkg::out_t exp_res;
    if (rst_n && out_valid) begin
      if (swipe_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_res);
      end else begin
        exp_res = swipe_results.pop_front();
        if (out_res.accepted !== exp_res.accepted || out_res.direction !== exp_res.direction ||
            out_res.swipe_speed !== exp_res.swipe_speed || out_res.fired !== exp_res.fired) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_res, out_res);
        end
      end
    end
  end

  // Writes one register; the trailing wait keeps writes from sharing a clock edge.
  task automatic write_reg(sgd_pkg::cfg_idx_t idx, logic [sgd_pkg::CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      sgd_pkg::CFG_DIR_MASK: mask_q = val[3:0];
      sgd_pkg::CFG_SETTLE:   settle_q = val;
      sgd_pkg::CFG_STALL:    stall_q = val;
      default:               min_spd_q = val[15:0];
    endcase
    @(posedge clk);
  endtask

  // Stops requests, then waits for the result queue to drain and any trailing work.
  task automatic wait_idle();
    int n;
    n = 0;
    start <= 1'b0;
    while ((swipe_results.size() != 0 || busy) && n < 100000) begin
      @(posedge clk);
      n++;
    end
    repeat (250) @(posedge clk);
  endtask

  // Sends one request after a random gap. start is left high on return so that a
  // request with no gap can follow at once; wait_idle lowers it.
  task automatic send_request(sgd_pkg::in_t r, bit no_gap = 0);
    int gap;
    gap = no_gap ? 0 : ($urandom_range(0, 3) == 0 ? int'($urandom_range(0, 13)) : 0);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_request(r);
  endtask

  function automatic sgd_pkg::in_t mk(sgd_pkg::cmd_t c, logic [2:0] b, int x, int y,
                                      logic [31:0] t, bit s = 0);
    sgd_pkg::in_t r;
    r.command = c; r.button = b; r.pos_x = x[15:0]; r.pos_y = y[15:0];
    r.time_us = t; r.suppress = s;
    return r;
  endfunction

  // Sends a full swipe: press, moves along a heading with random content, release.
  task automatic send_swipe(int npts, int vx, int vy, int step_us, bit sup, bit noisy);
    logic [2:0] b;
    int x, y;
    logic [31:0] t;
    b = 3'($urandom_range(1, 7));
    x = int'($urandom_range(0, 4000)) - 2000;
    y = int'($urandom_range(0, 4000)) - 2000;
    t = $urandom;
    send_request(mk(sgd_pkg::CMD_PRESS, b, x, y, t));
    for (int i = 0; i < npts; i++) begin
      x += vx + (noisy ? int'($urandom_range(0, 6)) - 3 : 0);
      y += vy + (noisy ? int'($urandom_range(0, 6)) - 3 : 0);
      t = t + 32'(step_us) + (noisy ? 32'($urandom_range(0, 200)) : 32'd0);
      if (i == npts - 1)
        send_request(mk(sgd_pkg::CMD_RELEASE, ($urandom_range(0, 15) == 0) ? b ^ 3'd1 : b,
                        x, y, t, sup));
      else
        send_request(mk(sgd_pkg::CMD_MOVE, 3'd0, x, y, t));
    end
    if (act_btn != 3'd0)
      send_request(mk(sgd_pkg::CMD_RELEASE, act_btn, x, y, t + 32'd20000));
  endtask

  // Directed table: a request, and its result where it is plain from the rules.
  typedef struct {
    sgd_pkg::in_t  req;
    bit            has_exp;
    sgd_pkg::out_t exp;
  } row_t;
  row_t directed[$];

  function automatic row_t row(sgd_pkg::in_t r, bit h, sgd_pkg::out_t e);
    row_t w;
    w.req = r;
    w.has_exp = h;
    w.exp = e;
    return w;
  endfunction

  initial begin
    int pick;
    mask_q = 4'hF; settle_q = 20'd10000; stall_q = 20'd10000; min_spd_q = 16'd0;
    clear_ring();
    tracking_q = 1'b0;
    act_btn = 3'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: unmatched releases, extremes, spurious command, ignored press.
    directed = '{
      row(mk(sgd_pkg::CMD_RELEASE, 3'd1, 0, 0, 32'd0), 1'b1, REJECTED),
      row(mk(sgd_pkg::CMD_MOVE, 3'd0, 32767, -32768, 32'hFFFF_FFFF), 1'b0, REJECTED),
      row(mk(sgd_pkg::CMD_NONE, 3'd7, -1, -1, 32'hFFFF_FFFF, 1), 1'b0, REJECTED),
      row(mk(sgd_pkg::CMD_PRESS, 3'd7, -32768, 32767, 32'hFFFF_FFFF), 1'b0, REJECTED),
      row(mk(sgd_pkg::CMD_PRESS, 3'd1, 0, 0, 32'd0), 1'b0, REJECTED),
      row(mk(sgd_pkg::CMD_RELEASE, 3'd6, 0, 0, 32'd5), 1'b1, REJECTED),
      row(mk(sgd_pkg::CMD_RELEASE, 3'd7, 32767, -32768, 32'd0, 1), 1'b1, SHORT_SWIPE)
    };
    foreach (directed[i]) begin
      send_request(directed[i].req);
      if (directed[i].has_exp) swipe_results[$] = directed[i].exp;
    end

    // Clean swipes in every direction, with a stationary head and a suppressed one.
    send_swipe(24, 0, -40, 1000, 0, 0);
    send_swipe(24, 0, 40, 1000, 0, 0);
    send_swipe(24, -40, 0, 1000, 1, 0);
    send_swipe(24, 40, 40, 1000, 0, 0);
    send_swipe(40, 3000, 0, 0, 0, 0);
    send_swipe(10, 40, 0, 1000, 0, 0);
    send_swipe(24, 0, 0, 20000, 0, 0);
    wait_idle();

    // Random phases through several register settings, extremes included.
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_reg(sgd_pkg::CFG_DIR_MASK, 20'h0); write_reg(sgd_pkg::CFG_SETTLE, 20'd0);
                 write_reg(sgd_pkg::CFG_STALL, 20'd0); write_reg(sgd_pkg::CFG_MIN_SPD, 20'd0); end
        1: begin write_reg(sgd_pkg::CFG_DIR_MASK, 20'hF);
                 write_reg(sgd_pkg::CFG_SETTLE, 20'd1000000);
                 write_reg(sgd_pkg::CFG_STALL, 20'd1000000);
                 write_reg(sgd_pkg::CFG_MIN_SPD, 20'hFFFF); end
        default: begin
          write_reg(sgd_pkg::CFG_DIR_MASK, 20'($urandom_range(0, 15)));
          write_reg(sgd_pkg::CFG_SETTLE, 20'($urandom_range(0, 3000)));
          write_reg(sgd_pkg::CFG_STALL, 20'($urandom_range(0, 1000000)));
          write_reg(sgd_pkg::CFG_MIN_SPD, ($urandom_range(0, 3) == 0) ?
                                          20'($urandom_range(0, 65535)) :
                                          20'($urandom_range(0, 2000)));
        end
      endcase
      for (int n = 0; n < 5; n++) begin
        pick = int'($urandom_range(0, 9));
        if (pick < 7)
          send_swipe(int'($urandom_range(18, 34)), int'($urandom_range(0, 120)) - 60,
                     int'($urandom_range(0, 120)) - 60, int'($urandom_range(0, 3000)),
                     $urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
        else
          for (int k = 0; k < 20; k++)
            send_request(mk(sgd_pkg::cmd_t'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                            int'($urandom), int'($urandom), $urandom,
                            1'($urandom_range(0, 1))));
      end
      wait_idle();
    end
    write_reg(sgd_pkg::CFG_DIR_MASK, 20'hF); write_reg(sgd_pkg::CFG_SETTLE, 20'd10000);
    write_reg(sgd_pkg::CFG_STALL, 20'd10000); write_reg(sgd_pkg::CFG_MIN_SPD, 20'd0);
    for (int n = 0; n < 15; n++)
      send_swipe(int'($urandom_range(20, 30)), int'($urandom_range(0, 160)) - 80,
                 int'($urandom_range(0, 160)) - 80, int'($urandom_range(100, 2000)),
                 $urandom_range(0, 4) == 0, 1'($urandom_range(0, 1)));
    wait_idle();

    if (mismatches == 0 && swipe_results.size() == 0)
      $display("[swipe_gesture_detector] OK");
    else
      $display("[swipe_gesture_detector] ERROR");
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #60000000;
    $display("[swipe_gesture_detector] ERROR");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/sgd_pkg.sv
hw/rtl/sgd_ram.sv
hw/rtl/swipe_gesture_detector.sv
verif/tb_swipe_gesture_detector.sv
